[hw/rtl/tdf_pkg.sv]
// shared constants and controller/datapath interface types for the factorizer
`timescale 1ns / 1ps

package tdf_pkg;

  localparam int NUMBER_BITS = 32;
  localparam int FACTOR_BITS = 32;
  localparam int MAX_RESULTS = 32;
  localparam int COUNT_BITS  = $clog2(MAX_RESULTS);

  typedef enum logic {
    SEL_PEND = 1'b0,
    SEL_REM  = 1'b1
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      start;
    logic      take;
    logic      inc;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic below3;
    logic div_done;
    logic d_gt_q;
    logic rem_zero;
    logic r_gt1;
    logic pend_valid;
    logic inner;
    logic at_cap;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/tdf_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tdf_div #(
  parameter int WIDTH = tdf_pkg::NUMBER_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CNT_BITS = $clog2(WIDTH);

  logic                run;
  logic [CNT_BITS-1:0] cnt;
  logic [WIDTH-1:0]    quo;
  logic [WIDTH-1:0]    rem;
  logic [WIDTH:0]      shifted;
  logic [WIDTH:0]      diff;

  assign shifted = {rem, quo[WIDTH-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_BITS'(WIDTH - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (run) begin
      // restore when the trial subtraction goes negative
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[hw/rtl/tdf_datapath.sv]
// factorizer datapath: remaining value, trial divisor, held factor, result register
`timescale 1ns / 1ps

module tdf_datapath #(
  parameter int NUMBER_BITS = tdf_pkg::NUMBER_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [NUMBER_BITS-1:0]           number,
  input  tdf_pkg::cmd_t                    cmd,
  output tdf_pkg::status_t                 status,
  output logic [tdf_pkg::FACTOR_BITS-1:0]  factor,
  output logic                             last,
  output logic                             factor_valid,
  input  logic                             factor_ready
);

  localparam int EXT_BITS = (NUMBER_BITS > tdf_pkg::FACTOR_BITS) ?
                            NUMBER_BITS : tdf_pkg::FACTOR_BITS;

  logic [NUMBER_BITS-1:0]         remaining;
  logic [NUMBER_BITS-1:0]         divisor;
  logic [NUMBER_BITS-1:0]         pend;
  logic                           pend_valid;
  logic                           inner;
  logic [tdf_pkg::COUNT_BITS-1:0] count;
  logic [NUMBER_BITS-1:0]         quotient;
  logic [NUMBER_BITS-1:0]         remainder;
  logic                           div_done;
  logic [NUMBER_BITS-1:0]         emit_val;
  logic [EXT_BITS-1:0]            emit_ext;

  tdf_div #(.WIDTH(NUMBER_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start),
    .dividend  (remaining),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      inner      <= 1'b0;
      count      <= '0;
    end else if (cmd.load) begin
      pend_valid <= 1'b0;
      inner      <= 1'b0;
      count      <= '0;
    end else if (cmd.take) begin
      pend_valid <= 1'b1;
      inner      <= 1'b1;
      count      <= count + 1'b1;
    end else if (cmd.inc) begin
      inner <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remaining <= number;
      divisor   <= NUMBER_BITS'(2);
    end else if (cmd.take) begin
      remaining <= quotient;
      pend      <= divisor;
    end else if (cmd.inc) begin
      divisor <= divisor + 1'b1;
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      tdf_pkg::SEL_REM: emit_val = remaining;
      default:          emit_val = pend;
    endcase
  end

  assign emit_ext = EXT_BITS'(emit_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_valid <= 1'b0;
    end else if (cmd.emit) begin
      factor_valid <= 1'b1;
    end else if (factor_ready) begin
      factor_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      factor <= emit_ext[tdf_pkg::FACTOR_BITS-1:0];
      last   <= cmd.emit_last;
    end
  end

  assign status.below3     = (number < NUMBER_BITS'(3));
  assign status.div_done   = div_done;
  assign status.d_gt_q     = (divisor > quotient);
  assign status.rem_zero   = (remainder == '0);
  assign status.r_gt1      = (remaining > NUMBER_BITS'(1));
  assign status.pend_valid = pend_valid;
  assign status.inner      = inner;
  assign status.at_cap     = (count == tdf_pkg::COUNT_BITS'(tdf_pkg::MAX_RESULTS - 1));
  assign status.out_free   = !factor_valid || factor_ready;

endmodule

[hw/rtl/tdf_ctrl.sv]
// factorizer controller: sequences trial divisions and result emission
`timescale 1ns / 1ps

module tdf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             number_valid,
  output logic             number_ready,
  input  tdf_pkg::status_t status,
  output tdf_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_START  = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_LAST_P = 6'b010000,
    ST_LAST_R = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign number_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (number_valid) begin
          cmd.load   = 1'b1;
          state_next = status.below3 ? ST_LAST_R : ST_START;
        end
      end
      ST_START: begin
        cmd.start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.inner && status.d_gt_q) begin
          // trials done, leftover above one is itself prime
          if (!status.r_gt1) begin
            state_next = ST_LAST_P;
          end else if (!status.pend_valid) begin
            state_next = ST_LAST_R;
          end else if (status.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = tdf_pkg::SEL_PEND;
            state_next   = ST_LAST_R;
          end
        end else if (status.rem_zero) begin
          // held factor goes out once the next one is known
          if (!status.pend_valid || status.out_free) begin
            cmd.emit     = status.pend_valid;
            cmd.emit_sel = tdf_pkg::SEL_PEND;
            cmd.take     = 1'b1;
            state_next   = status.at_cap ? ST_LAST_P : ST_START;
          end
        end else begin
          cmd.inc    = 1'b1;
          state_next = ST_START;
        end
      end
      ST_LAST_P: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = tdf_pkg::SEL_PEND;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_LAST_R: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = tdf_pkg::SEL_REM;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/trial_division_factorizer.sv]
// top level of the trial-division prime factorizer
//
//   channel   signals                        direction  content
//   number    number_valid/ready, number     in         value to factor
//   factor    factor_valid/ready, factor     out        prime factor, last flag
//
// each trial is one bit-serial division of the remaining value; trials run up
// to the square root of the value plus one per factor found, so a 32-bit prime
// takes up to ~65536 trials. inputs below three skip the trials.
// reset needs no clearing pass; one request is worked at a time.
// a full result register holds the controller until the result is taken.
`timescale 1ns / 1ps

module trial_division_factorizer #(
  parameter int NUMBER_BITS = tdf_pkg::NUMBER_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [NUMBER_BITS-1:0]          number,
  input  logic                            number_valid,
  output logic                            number_ready,
  output logic [tdf_pkg::FACTOR_BITS-1:0] factor,
  output logic                            last,
  output logic                            factor_valid,
  input  logic                            factor_ready
);

  tdf_pkg::cmd_t    cmd;
  tdf_pkg::status_t status;

  tdf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .number_valid (number_valid),
    .number_ready (number_ready),
    .status       (status),
    .cmd          (cmd)
  );

  tdf_datapath #(.NUMBER_BITS(NUMBER_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .number       (number),
    .cmd          (cmd),
    .status       (status),
    .factor       (factor),
    .last         (last),
    .factor_valid (factor_valid),
    .factor_ready (factor_ready)
  );

endmodule

[hw/rtl/tdf_checker.sv]
// port-level checks for the factorizer and their bind to the top level
`timescale 1ns / 1ps

module tdf_checker #(
  parameter int NUMBER_BITS = tdf_pkg::NUMBER_BITS
) (
  input logic                            clk,
  input logic                            rst,
  input logic [NUMBER_BITS-1:0]          number,
  input logic                            number_valid,
  input logic                            number_ready,
  input logic [tdf_pkg::FACTOR_BITS-1:0] factor,
  input logic                            last,
  input logic                            factor_valid,
  input logic                            factor_ready
);

  logic                            in_acc;
  logic                            out_acc;
  logic [1:0]                      open_cnt;
  logic                            first;
  logic [tdf_pkg::FACTOR_BITS-1:0] prev;

  assign in_acc  = number_valid && number_ready;
  assign out_acc = factor_valid && factor_ready;

  // requests whose final result has not been taken yet
  always_ff @(posedge clk) begin
    if (rst) begin
      open_cnt <= '0;
      first    <= 1'b1;
    end else begin
      case ({in_acc, out_acc && last})
        2'b10:   open_cnt <= open_cnt + 2'd1;
        2'b01:   open_cnt <= open_cnt - 2'd1;
        default: open_cnt <= open_cnt;
      endcase
      if (out_acc) begin
        first <= last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev <= factor;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    factor_valid && !factor_ready |=> factor_valid && $stable(factor) && $stable(last))
    else $error("stalled result changed");

  // no result without an open request
  assert property (@(posedge clk) disable iff (rst)
    factor_valid |-> open_cnt != 2'd0)
    else $error("result with no request open");

  // a new request only once the previous final result is out
  assert property (@(posedge clk) disable iff (rst)
    in_acc && open_cnt != 2'd0 |-> factor_valid && last)
    else $error("request taken before previous one finished");

  // factors of one number never decrease
  assert property (@(posedge clk) disable iff (rst)
    out_acc && !first |-> (NUMBER_BITS > tdf_pkg::FACTOR_BITS) || (factor >= prev))
    else $error("factor order decreased");

endmodule

bind trial_division_factorizer tdf_checker #(.NUMBER_BITS(NUMBER_BITS)) u_tdf_checker (.*);
